### rtl/core/fpd_pkg.sv
// Package: shared types and constants for the framed packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package fpd_pkg;
  localparam int MaxPayload = 53;
  localparam int StoreDepth = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int HeaderBytes = 9;
  localparam int OverheadBytes = 11;
  localparam logic [7:0] SyncA = 8'hAA;
  localparam logic [7:0] SyncB = 8'h55;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0] VersionReset = 8'h01;
  localparam logic ActPush = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  packet_type;
    logic [7:0]  packet_flags;
    logic [15:0] sequence_number;
    logic [5:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        last;
  } out_item_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
  endfunction
endpackage
`default_nettype wire

### rtl/core/framed_packet_deframer.sv
// Top level: byte store, sequencer, shared CRC bit unit and result register.
// Usage: push bytes or a clear request on the in channel (action, rx_byte).
// Each accepted request is processed by a sequencer that reads the 64-entry
// byte store through one registered read port. A clear only empties the
// store; a push that leaves fewer than two bytes held ends without a scan.
// A sync hunt reads each entry in turn (read, wait, check), up to 64
// entries, then checks the tail byte when no sync is found. The header
// check reads 7 entries. A CRC check covers 7+len bytes, each with one
// read, one load and eight steps of the shared CRC bit unit, then checks
// the two CRC bytes. After a bad frame one byte is dropped and the scan
// repeats from the hunt. A good frame is emitted as one result per payload
// byte (one header-only result for an empty payload), each passing through
// read, load and hold steps; the block waits on out ready, so a stalled
// receiver holds the current result. in ready is high only when the
// sequencer is idle. cfg writes of the protocol version are always
// taken. Reset empties the store and sets the version to 1; store
// contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module framed_packet_deframer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fpd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fpd_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_HUNT_RD, S_HUNT_WT, S_HUNT_CHK, S_TAIL_RD, S_TAIL_WT, S_TAIL_CHK,
    S_HDR_RD, S_HDR_WT, S_HDR_CHK, S_CRC_RD, S_CRC_WT, S_CRC_BIT, S_CMP_RD,
    S_CMP_WT, S_CMP_CHK, S_OUT_RD, S_OUT_WT, S_OUT_HOLD
  } state_t;

  state_t state;
  logic [7:0] mem [fpd_pkg::StoreDepth];
  logic [7:0] rd_data;
  logic [fpd_pkg::IdxW-1:0] rd_addr;
  logic rd_en;
  logic [fpd_pkg::CntW-1:0] fill_count;
  logic [fpd_pkg::IdxW-1:0] head_offset;
  logic [7:0] version;
  logic [fpd_pkg::CntW-1:0] idx;
  logic [7:0] prev;
  logic [2:0] bitn;
  logic [15:0] crc;
  logic [5:0] len;
  logic [7:0] ptype, pflags;
  logic [15:0] seqn;
  logic [7:0] got_lo;
  logic [fpd_pkg::CntW-1:0] total;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign total     = fpd_pkg::CntW'(fpd_pkg::OverheadBytes) + {1'b0, len};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_offset + idx[fpd_pkg::IdxW-1:0];
    case (state)
      S_HUNT_RD, S_TAIL_RD, S_HDR_RD, S_CRC_RD, S_CMP_RD, S_OUT_RD: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.action == fpd_pkg::ActPush) begin
      mem[head_offset + fill_count[fpd_pkg::IdxW-1:0]] <= in_data.rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_count  <= '0;
      head_offset <= '0;
      version     <= fpd_pkg::VersionReset;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        version <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.action == fpd_pkg::ActClear) begin
              fill_count  <= '0;
              head_offset <= '0;
            end else begin
              fill_count <= fill_count + 1'b1;
              idx        <= '0;
              state      <= S_HUNT_RD;
            end
          end
        end
        S_HUNT_RD: begin
          if (fill_count < 2) begin
            state <= S_IDLE;
          end else if (idx == fill_count) begin
            idx   <= fill_count - 1'b1;
            state <= S_TAIL_RD;
          end else begin
            state <= S_HUNT_WT;
          end
        end
        S_HUNT_WT: state <= S_HUNT_CHK;
        S_HUNT_CHK: begin
          if (idx != 0 && prev == fpd_pkg::SyncA && rd_data == fpd_pkg::SyncB) begin
            head_offset <= head_offset + fpd_pkg::IdxW'(idx - 1'b1);
            fill_count  <= fill_count - (idx - 1'b1);
            if (fill_count - (idx - 1'b1) < fpd_pkg::HeaderBytes) begin
              state <= S_IDLE;
            end else begin
              idx   <= 7'd2;
              state <= S_HDR_RD;
            end
          end else begin
            prev  <= rd_data;
            idx   <= idx + 1'b1;
            state <= S_HUNT_RD;
          end
        end
        S_TAIL_RD: state <= S_TAIL_WT;
        S_TAIL_WT: state <= S_TAIL_CHK;
        S_TAIL_CHK: begin
          if (rd_data == fpd_pkg::SyncA) begin
            head_offset <= head_offset + fpd_pkg::IdxW'(fill_count - 1'b1);
            fill_count  <= 7'd1;
          end else begin
            head_offset <= head_offset + fpd_pkg::IdxW'(fill_count);
            fill_count  <= '0;
          end
          state <= S_IDLE;
        end
        S_HDR_RD: state <= S_HDR_WT;
        S_HDR_WT: state <= S_HDR_CHK;
        S_HDR_CHK: begin
          idx   <= idx + 1'b1;
          state <= S_HDR_RD;
          case (idx)
            7'd2: if (rd_data != version) begin
              head_offset <= head_offset + 1'b1;
              fill_count  <= fill_count - 1'b1;
              idx         <= '0;
              state       <= S_HUNT_RD;
            end
            7'd3: ptype <= rd_data;
            7'd4: pflags <= rd_data;
            7'd5: seqn[7:0] <= rd_data;
            7'd6: seqn[15:8] <= rd_data;
            7'd7: got_lo <= rd_data;
            default: begin
              if (rd_data != 0 || got_lo > fpd_pkg::MaxPayload) begin
                head_offset <= head_offset + 1'b1;
                fill_count  <= fill_count - 1'b1;
                idx         <= '0;
                state       <= S_HUNT_RD;
              end else begin
                len <= got_lo[5:0];
                if (fill_count <
                    fpd_pkg::CntW'(fpd_pkg::OverheadBytes) + {1'b0, got_lo[5:0]}) begin
                  state <= S_IDLE;
                end else begin
                  crc   <= fpd_pkg::CrcInit;
                  idx   <= 7'd2;
                  state <= S_CRC_RD;
                end
              end
            end
          endcase
        end
        S_CRC_RD: begin
          if (idx == fpd_pkg::CntW'(fpd_pkg::HeaderBytes) + {1'b0, len}) begin
            state <= S_CMP_RD;
          end else begin
            state <= S_CRC_WT;
          end
        end
        S_CRC_WT: begin
          crc   <= crc ^ {rd_data, 8'h00};
          bitn  <= '0;
          state <= S_CRC_BIT;
        end
        S_CRC_BIT: begin
          crc  <= fpd_pkg::crc_bit(crc);
          bitn <= bitn + 1'b1;
          if (bitn == 3'd7) begin
            idx   <= idx + 1'b1;
            state <= S_CRC_RD;
          end
        end
        S_CMP_RD: state <= S_CMP_WT;
        S_CMP_WT: state <= S_CMP_CHK;
        S_CMP_CHK: begin
          if (idx == fpd_pkg::CntW'(fpd_pkg::HeaderBytes) + {1'b0, len}) begin
            if (rd_data != crc[7:0]) begin
              head_offset <= head_offset + 1'b1;
              fill_count  <= fill_count - 1'b1;
              idx         <= '0;
              state       <= S_HUNT_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_CMP_RD;
            end
          end else if (rd_data != crc[15:8]) begin
            head_offset <= head_offset + 1'b1;
            fill_count  <= fill_count - 1'b1;
            idx         <= '0;
            state       <= S_HUNT_RD;
          end else begin
            idx   <= 7'd9;
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_WT;
        S_OUT_WT: begin
          out_valid                <= 1'b1;
          out_data.packet_type     <= ptype;
          out_data.packet_flags    <= pflags;
          out_data.sequence_number <= seqn;
          out_data.payload_length  <= len;
          out_data.byte_index      <= (len == 0) ? 6'd0 : 6'(idx - 7'd9);
          out_data.payload_byte    <= (len == 0) ? 8'd0 : rd_data;
          out_data.has_data        <= (len != 0);
          out_data.last            <= (len == 0) || (idx == 7'd8 + {1'b0, len});
          state                    <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              head_offset <= head_offset + fpd_pkg::IdxW'(total);
              fill_count  <= fill_count - total;
              state       <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT_HOLD) else $error("result outside hold");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 7'd64) else $error("store overfilled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.action == fpd_pkg::ActPush) |=> !in_ready)
    else $error("push not processed");
`endif
endmodule
`default_nettype wire
